>>> sv/i2p_pkg.sv
// Shared types, codes and operator table for the infix to postfix converter.
`default_nettype none
package i2p_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [5:0]       op_code_t;
  typedef logic [15:0]      handle_t;
  typedef logic [2:0]       prec_t;

  localparam op_code_t CODE_LPAR = 6'd11;
  localparam op_code_t CODE_RPAR = 6'd12;
  localparam op_code_t CODE_FUNC = 6'd13;

  typedef enum logic [1:0] {
    OPC_OPERAND  = 2'd0,
    OPC_OPERATOR = 2'd1,
    OPC_END      = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_OPERAND = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_RPAR    = 2'd2,
    CMD_PUSH    = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_e;

  typedef struct packed {
    cmd_kind_e kind;
    op_code_t  code;
    handle_t   handle;
    prec_t     prec;
    logic      cmp;
  } cmd_t;

  typedef struct packed {
    logic     is_operator;
    op_code_t op;
    handle_t  operand;
    status_e  status;
    logic     last;
  } res_t;

  function automatic prec_t prec_of(input op_code_t code);
    prec_t p;
    case (code) inside
      6'd0, 6'd1:         p = 3'd1;
      6'd2, 6'd3:         p = 3'd2;
      6'd4, 6'd5:         p = 3'd3;
      6'd6:               p = 3'd4;
      [6'd7:6'd10]:       p = 3'd0;
      6'd11, 6'd12:       p = 3'd1;
      default:            p = 3'd5;
    endcase
    return p;
  endfunction

  function automatic logic rassoc_of(input op_code_t code);
    return (code == 6'd5) || (code == 6'd6);
  endfunction

endpackage
`default_nettype wire

>>> sv/infix_to_postfix_shunting_yard_unit.sv
// Top level of the shunting-yard infix to postfix converter.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   requests | push / full        | opcode_i, operator_code_i, operand_handle_i
//   results  | empty / pop        | is_operator_o, out_operator_o, out_operand_o,
//            |                    | status_o, last_o
//
// The front end takes one request per cycle, while it is not full, into a
// two-entry command queue. The back end pops each operator off the stack in
// its own step and then closes the request in a final step.
// Reset clears the queues and the stack depth; stack entries are not cleared.
// A full result queue stalls result writes; a full command queue raises full.
`default_nettype none
module infix_to_postfix_shunting_yard_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push,
  output logic         full,
  input  wire  [1:0]   opcode_i,
  input  wire  [5:0]   operator_code_i,
  input  wire  [15:0]  operand_handle_i,
  output logic         empty,
  input  wire          pop,
  output logic         is_operator_o,
  output logic [5:0]   out_operator_o,
  output logic [15:0]  out_operand_o,
  output logic [1:0]   status_o,
  output logic         last_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  i2p_pkg::cmd_t cmd;
  i2p_pkg::res_t res;

  i2p_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .opcode_i         (opcode_i),
    .operator_code_i  (operator_code_i),
    .operand_handle_i (operand_handle_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  i2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign is_operator_o  = res.is_operator;
  assign out_operator_o = res.op;
  assign out_operand_o  = res.operand;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule
`default_nettype wire

>>> sv/i2p_front.sv
// Front end: accepts input requests, classifies them and queues commands.
`default_nettype none
module i2p_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  wire  [1:0]           opcode_i,
  input  wire  [5:0]           operator_code_i,
  input  wire  [15:0]          operand_handle_i,
  output logic                 cmd_valid_o,
  output i2p_pkg::cmd_t        cmd_o,
  input  wire                  cmd_pop_i
);

  i2p_pkg::cmd_t cq_mem_q [2];
  logic          cq_wr_q, cq_rd_q;
  logic [1:0]    cq_cnt_q;
  i2p_pkg::cmd_t cmd_new;
  logic          keep;
  logic          wr_en, rd_en;

  always_comb begin
    cmd_new        = '0;
    cmd_new.code   = operator_code_i;
    cmd_new.handle = operand_handle_i;
    cmd_new.prec   = i2p_pkg::prec_of(operator_code_i);
    cmd_new.cmp    = (operator_code_i != i2p_pkg::CODE_LPAR) &&
                     (operator_code_i < i2p_pkg::CODE_FUNC);
    keep           = 1'b1;
    case (opcode_i)
      i2p_pkg::OPC_OPERAND: begin
        cmd_new.kind = i2p_pkg::CMD_OPERAND;
      end
      i2p_pkg::OPC_END: begin
        cmd_new.kind = i2p_pkg::CMD_FLUSH;
      end
      i2p_pkg::OPC_OPERATOR: begin
        if (operator_code_i == i2p_pkg::CODE_RPAR) begin
          cmd_new.kind = i2p_pkg::CMD_RPAR;
        end else begin
          cmd_new.kind = i2p_pkg::CMD_PUSH;
        end
      end
      default: begin
        cmd_new.kind = i2p_pkg::CMD_OPERAND;
        keep         = 1'b0;
      end
    endcase
  end

  assign full        = (cq_cnt_q == 2'd2);
  assign cmd_valid_o = (cq_cnt_q != 2'd0);
  assign cmd_o       = cq_mem_q[cq_rd_q];
  assign wr_en       = push && !full && keep;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wr_q  <= 1'b0;
      cq_rd_q  <= 1'b0;
      cq_cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        cq_wr_q <= ~cq_wr_q;
      end
      if (rd_en) begin
        cq_rd_q <= ~cq_rd_q;
      end
      case ({wr_en, rd_en})
        2'b10:   cq_cnt_q <= cq_cnt_q + 2'd1;
        2'b01:   cq_cnt_q <= cq_cnt_q - 2'd1;
        default: cq_cnt_q <= cq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cq_mem_q[cq_wr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

>>> sv/i2p_back.sv
// Back end: operator stack engine, pending result stage and result queue.
`default_nettype none
module i2p_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cmd_valid_i,
  input  i2p_pkg::cmd_t        cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty,
  input  wire                  pop,
  output i2p_pkg::res_t        res_o
);

  i2p_pkg::op_code_t stack_q [i2p_pkg::STACK_DEPTH];
  i2p_pkg::cnt_t     cnt_q;
  logic              pend_v_q;
  i2p_pkg::res_t     pend_q;
  i2p_pkg::res_t     rq_mem_q [2];
  logic              rq_wr_q, rq_rd_q;
  logic [1:0]        rq_cnt_q;

  i2p_pkg::idx_t     top_idx;
  i2p_pkg::op_code_t top;
  i2p_pkg::prec_t    top_prec;
  logic              top_ra;
  logic              nonempty, top_lpar, room, rq_full;
  logic              do_pop, step, finish, need;
  logic              res_push, rq_pop;
  i2p_pkg::res_t     res_item, pend_last, pend_d;

  always_comb begin
    top_idx   = i2p_pkg::idx_t'(cnt_q - 1'b1);
    top       = stack_q[top_idx];
    top_prec  = i2p_pkg::prec_of(top);
    top_ra    = i2p_pkg::rassoc_of(top);
    nonempty  = (cnt_q != '0);
    top_lpar  = (top == i2p_pkg::CODE_LPAR);
    room      = (cnt_q < i2p_pkg::cnt_t'(i2p_pkg::STACK_DEPTH));
    rq_full   = (rq_cnt_q == 2'd2);
    pend_last = pend_q;
    pend_last.last = 1'b1;
    pend_d             = '0;
    pend_d.is_operator = 1'b1;
    pend_d.op          = top;
    pend_d.status      = i2p_pkg::ST_OK;

    case (cmd_i.kind)
      i2p_pkg::CMD_FLUSH: do_pop = nonempty;
      i2p_pkg::CMD_RPAR:  do_pop = nonempty && !top_lpar;
      i2p_pkg::CMD_PUSH:  do_pop = cmd_i.cmp && nonempty && !top_lpar &&
                                   ((cmd_i.prec < top_prec) ||
                                    ((cmd_i.prec == top_prec) && !top_ra));
      default:            do_pop = 1'b0;
    endcase

    res_item = '0;
    need     = 1'b0;
    case (cmd_i.kind)
      i2p_pkg::CMD_OPERAND: begin
        need             = 1'b1;
        res_item.operand = cmd_i.handle;
        res_item.last    = 1'b1;
      end
      i2p_pkg::CMD_FLUSH: begin
        need     = pend_v_q;
        res_item = pend_last;
      end
      i2p_pkg::CMD_RPAR: begin
        need = 1'b1;
        if (pend_v_q) begin
          res_item = pend_last;
          if (!nonempty) begin
            res_item.status = i2p_pkg::ST_UNMATCHED;
          end
        end else if (!nonempty) begin
          res_item.status = i2p_pkg::ST_UNMATCHED;
          res_item.last   = 1'b1;
        end else begin
          need = 1'b0;
        end
      end
      i2p_pkg::CMD_PUSH: begin
        if (room) begin
          need     = pend_v_q;
          res_item = pend_last;
        end else begin
          need            = 1'b1;
          res_item.status = i2p_pkg::ST_OVERFLOW;
          res_item.last   = 1'b1;
        end
      end
      default: begin
        need = 1'b0;
      end
    endcase

    step     = 1'b0;
    finish   = 1'b0;
    res_push = 1'b0;
    if (cmd_valid_i) begin
      if (do_pop) begin
        step     = !(pend_v_q && rq_full);
        res_push = step && pend_v_q;
        res_item = pend_q;
      end else begin
        finish   = !(need && rq_full);
        res_push = finish && need;
      end
    end
  end

  assign cmd_pop_o = finish;
  assign empty     = (rq_cnt_q == 2'd0);
  assign res_o     = rq_mem_q[rq_rd_q];
  assign rq_pop    = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (step) begin
        cnt_q    <= cnt_q - 1'b1;
        pend_v_q <= 1'b1;
      end else if (finish) begin
        pend_v_q <= 1'b0;
        case (cmd_i.kind)
          i2p_pkg::CMD_RPAR: begin
            if (nonempty) begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
          i2p_pkg::CMD_PUSH: begin
            if (room) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          default: begin
            cnt_q <= cnt_q;
          end
        endcase
      end
      if (res_push) begin
        rq_wr_q <= ~rq_wr_q;
      end
      if (rq_pop) begin
        rq_rd_q <= ~rq_rd_q;
      end
      case ({res_push, rq_pop})
        2'b10:   rq_cnt_q <= rq_cnt_q + 2'd1;
        2'b01:   rq_cnt_q <= rq_cnt_q - 2'd1;
        default: rq_cnt_q <= rq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pend_q <= pend_d;
    end
    if (finish && (cmd_i.kind == i2p_pkg::CMD_PUSH) && room) begin
      stack_q[i2p_pkg::idx_t'(cnt_q)] <= cmd_i.code;
    end
    if (res_push) begin
      rq_mem_q[rq_wr_q] <= res_item;
    end
  end

endmodule
`default_nettype wire
